// ----- hdl/ccmc_pkg.sv -----
package ccmc_pkg;

    localparam int unsigned MAX_RES = 3;

    typedef enum logic [2:0] {
        K_SET_DEVICE = 3'd0,
        K_REQUEST    = 3'd1,
        K_READY      = 3'd2,
        K_CONFIRMED  = 3'd3,
        K_FAILED     = 3'd4,
        K_CLOSED     = 3'd5,
        K_TICK       = 3'd6,
        K_UNUSED     = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        R_PUBLISH    = 2'd0,
        R_CONNECT    = 2'd1,
        R_DISCONNECT = 2'd2,
        R_SET_MODE   = 2'd3
    } t_rkind;

    localparam logic [1:0] AV_UNAV  = 2'd0;
    localparam logic [1:0] AV_CONN  = 2'd1;
    localparam logic [1:0] AV_READY = 2'd2;
    localparam logic [1:0] AV_FAULT = 2'd3;

    localparam logic [2:0] ER_NONE     = 3'd0;
    localparam logic [2:0] ER_UNSUP    = 3'd2;
    localparam logic [2:0] ER_PROTO    = 3'd3;
    localparam logic [2:0] ER_CONNFAIL = 3'd4;
    localparam logic [2:0] ER_DISC     = 3'd5;
    localparam logic [2:0] ER_REJECT   = 3'd6;
    localparam logic [2:0] ER_TIMEOUT  = 3'd7;

    localparam logic [0:0] CFG_CONFIRM = 1'b0;
    localparam logic [0:0] CFG_RETRY   = 1'b1;

    // One result as it travels from the front to the back.
    typedef struct packed {
        t_rkind      kind;
        logic [15:0] sess;
        logic [1:0]  avail;
        logic [2:0]  caps;
        logic        cvalid;
        logic [1:0]  cmode;
        logic        pvalid;
        logic [1:0]  pmode;
        logic [2:0]  err;
        logic [1:0]  mode;
        logic        last;
    } t_res;

    // Up to three results caused by one event.
    typedef struct packed {
        logic [1:0] count;
        t_res       r0;
        t_res       r1;
        t_res       r2;
    } t_bundle;

endpackage

// ----- hdl/ccmc_front.sv -----
module ccmc_front #(
    parameter int SESSION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [2:0]         i_kind,
    input  logic               i_model_supported,
    input  logic               i_link_connected,
    input  logic [15:0]        i_event_session,
    input  logic [1:0]         i_mode_value,
    input  logic [2:0]         i_capability_bits,
    input  logic [2:0]         i_fail_code,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output ccmc_pkg::t_bundle  o_bundle
);
    import ccmc_pkg::*;

    logic [15:0] r_confirm_ticks, r_retry_ticks;
    logic [SESSION_BITS-1:0] r_sess, n_sess;
    logic r_conn, n_conn, r_sup, n_sup;
    logic [1:0] r_avail, n_avail;
    logic [2:0] r_cap, n_cap, r_conf, n_conf, r_pend, n_pend;
    logic [2:0] r_infl, n_infl, r_queu, n_queu, r_err, n_err;
    logic [15:0] r_ccd, n_ccd, r_rcd, n_rcd;

    t_res   rs [MAX_RES];
    logic [1:0] cnt;
    logic   match;
    logic [15:0] sess16;
    logic [15:0] ld_conf, ld_retry;
    logic [15:0] ccd_dec, rcd_dec;
    logic [2:0] vm;

    // Session tag as it appears on the 16-bit port.
    function automatic logic [15:0] tag16(input logic [SESSION_BITS-1:0] s);
        logic [63:0] w;
        w = 64'(s);
        return w[15:0];
    endfunction

    always_comb begin
        match    = (SESSION_BITS'(i_event_session) == r_sess);
        ld_conf  = (r_confirm_ticks == 16'd0) ? 16'd1 : r_confirm_ticks;
        ld_retry = (r_retry_ticks == 16'd0) ? 16'd1 : r_retry_ticks;
        ccd_dec  = r_ccd - 16'd1;
        rcd_dec  = r_rcd - 16'd1;
        vm       = {1'b1, i_mode_value};
        n_sess = r_sess; n_conn = r_conn; n_sup = r_sup; n_avail = r_avail;
        n_cap = r_cap; n_conf = r_conf; n_pend = r_pend; n_infl = r_infl;
        n_queu = r_queu; n_err = r_err; n_ccd = r_ccd; n_rcd = r_rcd;
        cnt = 2'd0;
        sess16 = 16'd0;
        for (int i = 0; i < MAX_RES; i++) rs[i] = '0;

        case (t_kind'(i_kind))
            K_SET_DEVICE: begin
                rs[0].kind = R_DISCONNECT;
                rs[0].sess = tag16(r_sess);
                n_sess = r_sess + 1'b1;
                n_ccd = '0; n_rcd = '0; n_infl = '0; n_queu = '0;
                n_sup = i_model_supported; n_avail = AV_UNAV; n_cap = '0;
                n_conf = '0; n_pend = '0; n_err = ER_NONE;
                n_conn = i_link_connected;
                if (!i_link_connected) begin
                    cnt = 2'd2;
                end else if (!i_model_supported) begin
                    n_err = ER_UNSUP;
                    cnt = 2'd2;
                end else begin
                    n_avail = AV_CONN;
                    n_sess = r_sess + 2'd2;
                    rs[2].kind = R_CONNECT;
                    rs[2].sess = tag16(r_sess + 2'd2);
                    cnt = 2'd3;
                end
                rs[1].kind = R_PUBLISH;
            end
            K_REQUEST: begin
                if (r_avail == AV_READY && i_mode_value != 2'd3
                    && r_cap[i_mode_value]) begin
                    if (r_pend[2]) begin
                        n_queu = vm; n_pend = vm;
                        rs[0].kind = R_PUBLISH;
                        cnt = 2'd1;
                    end else begin
                        n_infl = vm; n_pend = vm; n_err = ER_NONE;
                        n_ccd = ld_conf;
                        rs[0].kind = R_PUBLISH;
                        rs[1].kind = R_SET_MODE;
                        rs[1].sess = tag16(r_sess);
                        rs[1].mode = i_mode_value;
                        cnt = 2'd2;
                    end
                end
            end
            K_READY: begin
                if (match && r_avail == AV_CONN) begin
                    cnt = 2'd1;
                    rs[0].kind = R_PUBLISH;
                    if (!r_sup || i_capability_bits == 3'd0) begin
                        n_ccd = '0; n_infl = '0; n_queu = '0; n_pend = '0;
                        n_err = ER_PROTO; n_avail = AV_FAULT;
                    end else begin
                        n_avail = AV_READY; n_cap = i_capability_bits;
                        n_err = ER_NONE;
                    end
                end
            end
            K_CONFIRMED: begin
                if (match && r_avail == AV_READY && i_mode_value != 2'd3) begin
                    n_conf = vm; n_err = ER_NONE;
                    rs[0].kind = R_PUBLISH;
                    cnt = 2'd1;
                    if (!(r_infl[2] && r_infl[1:0] != i_mode_value)) begin
                        n_ccd = '0; n_infl = '0; n_queu = '0;
                        if (r_queu[2] && r_queu[1:0] != i_mode_value) begin
                            n_infl = r_queu; n_pend = r_queu; n_ccd = ld_conf;
                            rs[1].kind = R_SET_MODE;
                            rs[1].sess = tag16(r_sess);
                            rs[1].mode = r_queu[1:0];
                            cnt = 2'd2;
                        end else begin
                            n_pend = '0;
                        end
                    end
                end
            end
            K_FAILED: begin
                if (match && r_avail != AV_UNAV) begin
                    n_ccd = '0; n_infl = '0; n_queu = '0; n_pend = '0;
                    n_err = i_fail_code;
                    rs[0].kind = R_PUBLISH;
                    cnt = 2'd1;
                    if (r_conn && (i_fail_code == ER_CONNFAIL
                                   || i_fail_code == ER_DISC)) begin
                        n_avail = AV_CONN;
                        if (r_rcd == 16'd0) n_rcd = ld_retry;
                    end else if (i_fail_code == ER_REJECT && r_avail == AV_READY) begin
                        n_avail = r_avail;
                    end else begin
                        n_avail = AV_FAULT;
                    end
                end
            end
            K_CLOSED: begin
                if (match && r_conn && r_avail != AV_UNAV) begin
                    n_ccd = '0; n_infl = '0; n_queu = '0; n_avail = AV_CONN;
                    n_cap = '0; n_conf = '0; n_pend = '0; n_err = ER_DISC;
                    if (r_rcd == 16'd0) n_rcd = ld_retry;
                    rs[0].kind = R_PUBLISH;
                    cnt = 2'd1;
                end
            end
            K_TICK: begin
                if (r_ccd != 16'd0) begin
                    n_ccd = ccd_dec;
                    if (ccd_dec == 16'd0) begin
                        n_infl = '0; n_queu = '0; n_pend = '0; n_err = ER_TIMEOUT;
                        rs[0].kind = R_PUBLISH;
                        cnt = 2'd1;
                    end
                end
                if (r_rcd != 16'd0) begin
                    n_rcd = rcd_dec;
                    if (rcd_dec == 16'd0 && r_conn && r_sup && r_avail == AV_CONN) begin
                        n_sess = r_sess + 1'b1;
                        sess16 = tag16(r_sess + 1'b1);
                        if (cnt == 2'd0) begin
                            rs[0].kind = R_CONNECT; rs[0].sess = sess16;
                        end else begin
                            rs[1].kind = R_CONNECT; rs[1].sess = sess16;
                        end
                        cnt = cnt + 2'd1;
                    end
                end
            end
            default: cnt = 2'd0;
        endcase

        // Publications show the state as it stands after this event,
        // the middle publish of a set-device connect included; the final
        // connect of that event carries no state.
        for (int i = 0; i < MAX_RES; i++) begin
            if (rs[i].kind == R_PUBLISH && 2'(i) < cnt) begin
                rs[i].avail  = n_avail;
                rs[i].caps   = n_cap;
                rs[i].cvalid = n_conf[2];
                rs[i].cmode  = n_conf[2] ? n_conf[1:0] : 2'd0;
                rs[i].pvalid = n_pend[2];
                rs[i].pmode  = n_pend[2] ? n_pend[1:0] : 2'd0;
                rs[i].err    = n_err;
            end
            rs[i].last = (2'(i + 1) == cnt);
        end
        // A request's set-mode publish precedes the command; state equal.
        // A timeout publish precedes a connect; error/state equal as well.
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm_ticks <= 16'd500;
            r_retry_ticks   <= 16'd1000;
            r_sess <= '0; r_conn <= 1'b0; r_sup <= 1'b0; r_avail <= AV_UNAV;
            r_cap <= '0; r_conf <= '0; r_pend <= '0; r_infl <= '0;
            r_queu <= '0; r_err <= ER_NONE; r_ccd <= '0; r_rcd <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_CONFIRM) r_confirm_ticks <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_RETRY)   r_retry_ticks   <= i_cfg_data;
            if (i_go) begin
                r_sess <= n_sess; r_conn <= n_conn; r_sup <= n_sup;
                r_avail <= n_avail; r_cap <= n_cap; r_conf <= n_conf;
                r_pend <= n_pend; r_infl <= n_infl; r_queu <= n_queu;
                r_err <= n_err; r_ccd <= n_ccd; r_rcd <= n_rcd;
            end
        end
    end

    assign o_bundle = '{count: cnt, r0: rs[0], r1: rs[1], r2: rs[2]};

endmodule

// ----- hdl/ccmc_back.sv -----
module ccmc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ccmc_pkg::t_bundle i_bundle,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output ccmc_pkg::t_res    o_res
);
    import ccmc_pkg::*;

    // Two-entry bundle queue, then results are unpacked one per cycle while popped.
    t_bundle r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_fill;
    logic [1:0] r_idx;
    t_bundle head;
    logic take, done;

    always_comb begin
        head = r_q[r_rp];
        case (r_idx)
            2'd0:    o_res = head.r0;
            2'd1:    o_res = head.r1;
            default: o_res = head.r2;
        endcase
        o_empty = (r_fill == 2'd0);
        take    = i_pop && !o_empty;
        done    = take && (r_idx + 2'd1 == head.count);
        o_full  = (r_fill == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (i_push && i_bundle.count != 2'd0 && !o_full) r_q[r_wp] <= i_bundle;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_fill <= 2'd0; r_idx <= 2'd0;
        end else begin
            if (i_push && i_bundle.count != 2'd0 && !o_full) r_wp <= ~r_wp;
            if (take) r_idx <= done ? 2'd0 : r_idx + 2'd1;
            if (done) r_rp <= ~r_rp;
            r_fill <= r_fill + 2'((i_push && i_bundle.count != 2'd0 && !o_full))
                      - 2'(done);
        end
    end

endmodule

// ----- hdl/command_confirm_mode_controller_top.sv -----
// An accepted event's results enter the queue at the acceptance edge; with the queue
// empty, its first result is visible the cycle after acceptance. One event per cycle
// is accepted while the two-bundle queue has room; results drain one per cycle while
// pop is held. Events that cause no result update the front state and are not queued.
// Reset is synchronous, active low: state and queue clear, registers load 500/1000.
module command_confirm_mode_controller_top #(
    parameter int SESSION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_kind,
    input  logic        i_model_supported,
    input  logic        i_link_connected,
    input  logic [15:0] i_event_session,
    input  logic [1:0]  i_mode_value,
    input  logic [2:0]  i_capability_bits,
    input  logic [2:0]  i_fail_code,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_result_kind,
    output logic [15:0] o_cmd_session,
    output logic [1:0]  o_availability,
    output logic [2:0]  o_caps,
    output logic        o_confirmed_valid,
    output logic [1:0]  o_confirmed_mode,
    output logic        o_pending_valid,
    output logic [1:0]  o_pending_mode,
    output logic [2:0]  o_error_code,
    output logic [1:0]  o_cmd_mode,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import ccmc_pkg::*;

    t_bundle bundle;
    t_res    res;
    logic    go;

    // The front updates state on every accepted transfer; its results go
    // into the queue in the same edge.
    assign go = push && !full;

    ccmc_front #(.SESSION_BITS(SESSION_BITS)) u_front (
        .i_clk, .i_rst_n, .i_go(go), .i_kind, .i_model_supported,
        .i_link_connected, .i_event_session, .i_mode_value, .i_capability_bits,
        .i_fail_code, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_bundle(bundle)
    );

    ccmc_back u_back (
        .i_clk, .i_rst_n, .i_push(push), .i_bundle(bundle), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_res(res)
    );

    assign o_result_kind     = res.kind;
    assign o_cmd_session     = res.sess;
    assign o_availability    = res.avail;
    assign o_caps            = res.caps;
    assign o_confirmed_valid = res.cvalid;
    assign o_confirmed_mode  = res.cmode;
    assign o_pending_valid   = res.pvalid;
    assign o_pending_mode    = res.pmode;
    assign o_error_code      = res.err;
    assign o_cmd_mode        = res.mode;
    assign o_last            = res.last;

endmodule

// ----- hdl/ccmc_checker.sv -----
module ccmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       full,
    input logic [1:0] o_result_kind,
    input logic [15:0] o_cmd_session,
    input logic [1:0] o_cmd_mode
);
    import ccmc_pkg::*;

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("queue not empty after reset");
    a_pub_no_sess: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind == R_PUBLISH) |-> (o_cmd_session == 16'd0))
        else $error("publish carries a session");
    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_cmd_mode != 2'd3))
        else $error("illegal mode");
    a_full_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full after reset");
endmodule

bind command_confirm_mode_controller_top ccmc_checker u_chk (
    .i_clk, .i_rst_n, .empty, .full, .o_result_kind, .o_cmd_session, .o_cmd_mode
);

// ----- dv/command_confirm_mode_controller_checker.sv -----
module command_confirm_mode_controller_checker
    import ccmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [2:0]  i_kind,
    input  logic        i_model_supported,
    input  logic        i_link_connected,
    input  logic [15:0] i_event_session,
    input  logic [1:0]  i_mode_value,
    input  logic [2:0]  i_capability_bits,
    input  logic [2:0]  i_fail_code,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  o_result_kind,
    input  logic [15:0] o_cmd_session,
    input  logic [1:0]  o_availability,
    input  logic [2:0]  o_caps,
    input  logic        o_confirmed_valid,
    input  logic [1:0]  o_confirmed_mode,
    input  logic        o_pending_valid,
    input  logic [1:0]  o_pending_mode,
    input  logic [2:0]  o_error_code,
    input  logic [1:0]  o_cmd_mode,
    input  logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending_count,
    output int          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted controller state; mode stores carry a valid flag beside the mode.
    logic [15:0] cfg_confirm, cfg_retry, sess_ctr, confirm_cd, retry_cd;
    logic        link_up, model_ok;
    logic [1:0]  avail;
    logic [2:0]  caps, err;
    logic        conf_v, pend_v, infl_v, queu_v;
    logic [1:0]  conf_m, pend_m, infl_m, queu_m;

    t_res expected_results[$];
    t_res step_out[$];

    function automatic logic [15:0] load_ticks(logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    task automatic add_result(t_rkind k, logic [15:0] s, logic [1:0] m);
        t_res r;
        r = '0;
        r.kind = k;
        if (k == R_PUBLISH) begin
            r.avail  = avail;
            r.caps   = caps;
            r.cvalid = conf_v;
            r.cmode  = conf_v ? conf_m : 2'd0;
            r.pvalid = pend_v;
            r.pmode  = pend_v ? pend_m : 2'd0;
            r.err    = err;
        end else begin
            r.sess = s;
            r.mode = m;
        end
        step_out.push_back(r);
    endtask

    task automatic start_connect();
        sess_ctr = sess_ctr + 16'd1;
        add_result(R_CONNECT, sess_ctr, 2'd0);
    endtask

    task automatic send_mode(logic [1:0] m);
        infl_v = 1'b1; infl_m = m;
        pend_v = 1'b1; pend_m = m;
        err = ER_NONE;
        add_result(R_PUBLISH, '0, '0);
        confirm_cd = load_ticks(cfg_confirm);
        add_result(R_SET_MODE, sess_ctr, m);
    endtask

    task automatic handle_failure(logic [2:0] code);
        confirm_cd = '0;
        infl_v = 1'b0; queu_v = 1'b0; pend_v = 1'b0;
        err = code;
        if (link_up && (code == ER_CONNFAIL || code == ER_DISC)) begin
            avail = AV_CONN;
            add_result(R_PUBLISH, '0, '0);
            if (retry_cd == 16'd0) retry_cd = load_ticks(cfg_retry);
        end else if (code == ER_REJECT && avail == AV_READY) begin
            add_result(R_PUBLISH, '0, '0);
        end else begin
            avail = AV_FAULT;
            add_result(R_PUBLISH, '0, '0);
        end
    endtask

    task automatic predict_event();
        logic match;
        t_res r;
        match = (i_event_session == sess_ctr);
        step_out.delete();
        case (t_kind'(i_kind))
            K_SET_DEVICE: begin
                add_result(R_DISCONNECT, sess_ctr, 2'd0);
                sess_ctr = sess_ctr + 16'd1;
                confirm_cd = '0; retry_cd = '0;
                infl_v = 1'b0; queu_v = 1'b0; conf_v = 1'b0; pend_v = 1'b0;
                model_ok = i_model_supported;
                link_up = i_link_connected;
                avail = AV_UNAV;
                caps = '0;
                err = ER_NONE;
                if (!i_link_connected) begin
                    add_result(R_PUBLISH, '0, '0);
                end else if (!i_model_supported) begin
                    err = ER_UNSUP;
                    add_result(R_PUBLISH, '0, '0);
                end else begin
                    avail = AV_CONN;
                    add_result(R_PUBLISH, '0, '0);
                    start_connect();
                end
            end
            K_REQUEST: begin
                if (avail == AV_READY && i_mode_value != 2'd3 && caps[i_mode_value]) begin
                    if (pend_v) begin
                        queu_v = 1'b1; queu_m = i_mode_value;
                        pend_m = i_mode_value;
                        add_result(R_PUBLISH, '0, '0);
                    end else begin
                        send_mode(i_mode_value);
                    end
                end
            end
            K_READY: begin
                if (match && avail == AV_CONN) begin
                    if (!model_ok || i_capability_bits == 3'd0) begin
                        handle_failure(ER_PROTO);
                    end else begin
                        avail = AV_READY;
                        caps = i_capability_bits;
                        err = ER_NONE;
                        add_result(R_PUBLISH, '0, '0);
                    end
                end
            end
            K_CONFIRMED: begin
                if (match && avail == AV_READY && i_mode_value != 2'd3) begin
                    conf_v = 1'b1; conf_m = i_mode_value;
                    err = ER_NONE;
                    if (infl_v && infl_m != i_mode_value) begin
                        add_result(R_PUBLISH, '0, '0);
                    end else begin
                        confirm_cd = '0;
                        infl_v = 1'b0;
                        if (queu_v && queu_m != i_mode_value) begin
                            queu_v = 1'b0;
                            send_mode(queu_m);
                        end else begin
                            queu_v = 1'b0;
                            pend_v = 1'b0;
                            add_result(R_PUBLISH, '0, '0);
                        end
                    end
                end
            end
            K_FAILED: begin
                if (match && avail != AV_UNAV) handle_failure(i_fail_code);
            end
            K_CLOSED: begin
                if (match && link_up && avail != AV_UNAV) begin
                    confirm_cd = '0;
                    infl_v = 1'b0; queu_v = 1'b0; conf_v = 1'b0; pend_v = 1'b0;
                    avail = AV_CONN;
                    caps = '0;
                    err = ER_DISC;
                    add_result(R_PUBLISH, '0, '0);
                    if (retry_cd == 16'd0) retry_cd = load_ticks(cfg_retry);
                end
            end
            K_TICK: begin
                // The confirmation timer is serviced ahead of the retry timer.
                if (confirm_cd != 16'd0) begin
                    confirm_cd = confirm_cd - 16'd1;
                    if (confirm_cd == 16'd0) begin
                        infl_v = 1'b0; queu_v = 1'b0; pend_v = 1'b0;
                        err = ER_TIMEOUT;
                        add_result(R_PUBLISH, '0, '0);
                    end
                end
                if (retry_cd != 16'd0) begin
                    retry_cd = retry_cd - 16'd1;
                    if (retry_cd == 16'd0 && link_up && model_ok && avail == AV_CONN)
                        start_connect();
                end
            end
            default: ;
        endcase
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
        foreach (step_out[i]) expected_results.push_back(step_out[i]);
    endtask

    task automatic compare_result();
        t_res e;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result kind %0d", $time, o_result_kind);
            o_fail_count++;
            return;
        end
        e = expected_results.pop_front();
        if (o_result_kind != e.kind || o_cmd_session != e.sess
            || o_availability != e.avail || o_caps != e.caps
            || o_confirmed_valid != e.cvalid || o_confirmed_mode != e.cmode
            || o_pending_valid != e.pvalid || o_pending_mode != e.pmode
            || o_error_code != e.err || o_cmd_mode != e.mode || o_last != e.last) begin
            $display("%0t: mismatch expected kind=%0d sess=%h av=%0d caps=%0d cv=%0d cm=%0d pv=%0d pm=%0d err=%0d mode=%0d last=%0d",
                     $time, e.kind, e.sess, e.avail, e.caps, e.cvalid, e.cmode,
                     e.pvalid, e.pmode, e.err, e.mode, e.last);
            $display("%0t:          actual   kind=%0d sess=%h av=%0d caps=%0d cv=%0d cm=%0d pv=%0d pm=%0d err=%0d mode=%0d last=%0d",
                     $time, o_result_kind, o_cmd_session, o_availability, o_caps,
                     o_confirmed_valid, o_confirmed_mode, o_pending_valid,
                     o_pending_mode, o_error_code, o_cmd_mode, o_last);
            o_fail_count++;
        end
        o_result_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_confirm = 16'd500; cfg_retry = 16'd1000;
            sess_ctr = '0; confirm_cd = '0; retry_cd = '0;
            link_up = 1'b0; model_ok = 1'b0;
            avail = AV_UNAV; caps = '0; err = ER_NONE;
            conf_v = 1'b0; pend_v = 1'b0; infl_v = 1'b0; queu_v = 1'b0;
            conf_m = '0; pend_m = '0; infl_m = '0; queu_m = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CONFIRM) cfg_confirm = i_cfg_data;
                else cfg_retry = i_cfg_data;
            end
            if (pop && !empty) compare_result();
            if (push && !full) predict_event();
        end
        o_pending_count <= expected_results.size();
    end
endmodule

// ----- dv/command_confirm_mode_controller_top_test.sv -----
module command_confirm_mode_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ccmc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_kind = '0;
    logic        i_model_supported = 1'b0;
    logic        i_link_connected = 1'b0;
    logic [15:0] i_event_session = '0;
    logic [1:0]  i_mode_value = '0;
    logic [2:0]  i_capability_bits = '0;
    logic [2:0]  i_fail_code = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_result_kind;
    logic [15:0] o_cmd_session;
    logic [1:0]  o_availability;
    logic [2:0]  o_caps;
    logic        o_confirmed_valid;
    logic [1:0]  o_confirmed_mode;
    logic        o_pending_valid;
    logic [1:0]  o_pending_mode;
    logic [2:0]  o_error_code;
    logic [1:0]  o_cmd_mode;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_data = '0;

    int fail_count, pending_count, result_count;
    int idle_cycles;
    int events_sent;

    // The testbench mirrors the session counter so that most link events carry
    // the live tag; it follows the connect commands that it observes.
    logic [15:0] live_session;

    always #4 i_clk = ~i_clk;

    command_confirm_mode_controller_top i_dut (.*);

    command_confirm_mode_controller_checker i_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending_count(pending_count),
        .o_result_count(result_count)
    );

    // Track the live session from the connect commands seen at the output.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            live_session <= '0;
        end else if (pop && !empty && o_result_kind == R_CONNECT) begin
            live_session <= o_cmd_session;
        end
    end

    // Result side: a random stall before each pop, drawn afresh per transfer.
    // Some transfers draw no stall at all, so the queue at times drains at full rate.
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk iff !empty);
        end
    end

    // The watchdog restarts on every transfer in either direction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("command_confirm_mode_controller_top test failed");
            $finish;
        end
    end

    // One event transfer, after an optional random gap. Valid stays high until accepted,
    // and stays high into the next event when that one follows with no gap.
    task automatic send_event(logic [2:0] kind, logic msup, logic conn,
                              logic [15:0] sess, logic [1:0] mode,
                              logic [2:0] capb, logic [2:0] code,
                              bit allow_gap);
        int gap;
        gap = (allow_gap && $urandom_range(0, 2) != 0) ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push              <= 1'b1;
        i_kind            <= kind;
        i_model_supported <= msup;
        i_link_connected  <= conn;
        i_event_session   <= sess;
        i_mode_value      <= mode;
        i_capability_bits <= capb;
        i_fail_code       <= code;
        @(posedge i_clk iff !full);
        events_sent++;
    endtask

    // Let the queue empty out, then wait a little for any no-result event in flight.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0 || !empty) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // The live tag is used for most link events; otherwise any tag at all.
    function automatic logic [15:0] pick_session();
        if ($urandom_range(0, 9) < 8) return live_session;
        return 16'($urandom);
    endfunction

    // A well-formed session: set-up, ready, then requests and confirmations with
    // ticks and occasional failures, closes, readys or unused events mixed in as noise.
    task automatic random_session(int n_events);
        logic [1:0] m;
        int sel;
        send_event(K_SET_DEVICE, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
                   16'($urandom), 2'($urandom), 3'($urandom), 3'($urandom), 1'b1);
        push <= 1'b0;
        repeat (6) @(posedge i_clk);
        send_event(K_READY, 1'b0, 1'b0, pick_session(), 2'($urandom),
                   3'($urandom_range(0, 7)), 3'($urandom), 1'b1);
        for (int i = 0; i < n_events; i++) begin
            m = 2'($urandom_range(0, 3));
            sel = $urandom_range(0, 99);
            if (sel < 30)
                send_event(K_REQUEST, 1'($urandom), 1'($urandom), 16'($urandom), m,
                           3'($urandom), 3'($urandom), 1'b1);
            else if (sel < 55)
                send_event(K_CONFIRMED, 1'($urandom), 1'($urandom), pick_session(), m,
                           3'($urandom), 3'($urandom), 1'b1);
            else if (sel < 80)
                send_event(K_TICK, 1'($urandom), 1'($urandom), 16'($urandom), m,
                           3'($urandom), 3'($urandom), 1'b1);
            else if (sel < 88)
                send_event(K_FAILED, 1'($urandom), 1'($urandom), pick_session(), m,
                           3'($urandom), 3'($urandom), 1'b1);
            else if (sel < 93)
                send_event(K_CLOSED, 1'($urandom), 1'($urandom), pick_session(), m,
                           3'($urandom), 3'($urandom), 1'b1);
            else if (sel < 97)
                send_event(K_READY, 1'($urandom), 1'($urandom), pick_session(), m,
                           3'($urandom), 3'($urandom), 1'b1);
            else
                send_event(K_UNUSED, 1'($urandom), 1'($urandom), 16'($urandom), m,
                           3'($urandom), 3'($urandom), 1'b1);
        end
    endtask

    initial begin
        events_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with short timers so expiries are reached quickly.
        write_cfg(CFG_CONFIRM, 16'd2);
        write_cfg(CFG_RETRY, 16'd1);
        // Link down, then unsupported model, then a full connect.
        send_event(K_SET_DEVICE, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0);
        send_event(K_SET_DEVICE, 1'b0, 1'b1, '0, '0, '0, '0, 1'b0);
        send_event(K_SET_DEVICE, 1'b1, 1'b1, 16'hFFFF, 2'd3, 3'd7, 3'd7, 1'b0);
        wait_idle();
        // Ready with no capabilities is a protocol fault; a wrong tag is ignored.
        send_event(K_READY, 1'b0, 1'b0, live_session ^ 16'h8000, 2'd0, 3'd7, 3'd0, 1'b0);
        send_event(K_READY, 1'b0, 1'b0, live_session, 2'd0, 3'd0, 3'd0, 1'b0);
        // A disconnect failure moves back to connecting; the retry fires on a tick.
        send_event(K_FAILED, 1'b0, 1'b0, live_session, 2'd0, 3'd0, ER_DISC, 1'b0);
        send_event(K_TICK, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
        wait_idle();
        send_event(K_READY, 1'b0, 1'b0, live_session, 2'd0, 3'd7, 3'd0, 1'b0);
        // Mode value three is ignored; a second request queues behind the first.
        send_event(K_REQUEST, 1'b0, 1'b0, '0, 2'd3, '0, '0, 1'b0);
        send_event(K_REQUEST, 1'b0, 1'b0, '0, 2'd0, '0, '0, 1'b0);
        send_event(K_REQUEST, 1'b0, 1'b0, '0, 2'd2, '0, '0, 1'b0);
        send_event(K_CONFIRMED, 1'b0, 1'b0, live_session, 2'd3, '0, '0, 1'b0);
        send_event(K_CONFIRMED, 1'b0, 1'b0, live_session, 2'd0, '0, '0, 1'b0);
        // The confirmation timer expires on the second tick.
        send_event(K_TICK, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
        send_event(K_TICK, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
        send_event(K_REQUEST, 1'b0, 1'b0, '0, 2'd1, '0, '0, 1'b0);
        send_event(K_FAILED, 1'b0, 1'b0, live_session, 2'd0, '0, ER_REJECT, 1'b0);
        send_event(K_UNUSED, 1'b1, 1'b1, 16'hFFFF, 2'd3, 3'd7, 3'd7, 1'b0);
        send_event(K_CLOSED, 1'b0, 1'b0, live_session, 2'd0, '0, '0, 1'b0);
        send_event(K_FAILED, 1'b0, 1'b0, live_session, 2'd0, '0, ER_CONNFAIL, 1'b0);
        wait_idle();

        // Random part in phases, each with its own register settings; a zero
        // register value is included since it behaves as one.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_cfg(CFG_CONFIRM, 16'd1); write_cfg(CFG_RETRY, 16'd3); end
                1: begin write_cfg(CFG_CONFIRM, 16'd0); write_cfg(CFG_RETRY, 16'd0); end
                2: begin write_cfg(CFG_CONFIRM, 16'hFFFF); write_cfg(CFG_RETRY, 16'hFFFF); end
                default: begin
                    write_cfg(CFG_CONFIRM, 16'($urandom_range(1, 5)));
                    write_cfg(CFG_RETRY, 16'($urandom_range(1, 4)));
                end
            endcase
            for (int s = 0; s < 4; s++) random_session($urandom_range(2, 6));
            wait_idle();
        end

        // Let any trailing work settle before the verdict.
        repeat (20) @(posedge i_clk);
        $display("Sent %0d events across set-up, link, request and timer paths;", events_sent);
        $display("checked %0d results under six timer settings.", result_count);
        if (fail_count == 0)
            $display("command_confirm_mode_controller_top test passed");
        else
            $display("command_confirm_mode_controller_top test failed");
        $finish;
    end
endmodule
